[src/ukt_pkg.sv]
// shared widths, codes and types of the unsorted keyed table
package ukt_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned PAYLOAD_W    = 64;
  localparam int unsigned REC_W        = KEY_W + PAYLOAD_W;
  localparam int unsigned REQ_W        = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CNT_OUT_W    = 7;
  localparam int unsigned OUT_TDATA_W  = 112;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_DELETE     = 3'd1,
    REQ_RETRIEVE   = 3'd2,
    REQ_EMPTY      = 3'd3,
    REQ_RESET_ITER = 3'd4,
    REQ_NEXT       = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_AT_END    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_NEXT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                 found;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    status_e              status;
  } result_t;

endpackage

[src/ukt_ram.sv]
// record memory with one write port and one registered read port
module ukt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

[src/unsorted_keyed_table.sv]
// unsorted keyed table top level: request sequencer over the record memory
// retrieve and delete scan from index 0 until the key matches or all records are seen;
//   a delete with a hit then moves the last record into the freed slot
// one request in work at a time; the scan over memory compares one record per cycle;
//   a new request is taken while a result waits
// reset clears count, cursor and handshake state; record memory is not cleared
module unsorted_keyed_table import ukt_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [REC_W-1:0]       s_axis_tdata_i,   // key, payload
  input  logic [REQ_W-1:0]       s_axis_tuser_i,   // req_type
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // found, key_out, payload_out,
                                                   // entry_count, is_full, zero pad
  output logic [STATUS_W-1:0]    m_axis_tuser_o    // status
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned PAD_W = OUT_TDATA_W - (1 + KEY_W + PAYLOAD_W + CNT_OUT_W + 1);
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] scan_q, scan_d;
  logic cmp_vld_q, cmp_vld_d;
  logic [CW-1:0] cmp_idx_q, cmp_idx_d;
  logic [AW-1:0] loc_q, loc_d;
  logic del_q, del_d;
  logic [KEY_W-1:0] key_q, key_d;
  result_t res_q, res_d;
  logic m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic [STATUS_W-1:0] m_user_q, m_user_d;

  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [REC_W-1:0] rd_data, wr_data;

  logic accept, out_free, hit, scan_end;
  logic [KEY_W-1:0] rd_key;
  logic [CW-1:0] last_idx;
  logic [31:0] cnt_ext;
  req_e req;

  ukt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (REC_W),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign req      = req_e'(s_axis_tuser_i);
  assign rd_key   = rd_data[KEY_W-1:0];
  assign hit      = cmp_vld_q && (rd_key == key_q);
  assign scan_end = cmp_vld_q && !hit && ((cmp_idx_q + CW'(1)) == count_q);
  assign last_idx = count_q - CW'(1);
  assign cnt_ext  = 32'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_DELETE, REQ_RETRIEVE: state_d = (count_q == '0) ? S_DONE : S_SCAN;
            REQ_NEXT: state_d = (cursor_q < count_q) ? S_NEXT : S_DONE;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = del_q ? S_MOVE : S_DONE;
        end else if (scan_end) begin
          state_d = S_DONE;
        end
      end
      S_MOVE: state_d = S_DONE;
      S_NEXT: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d   = count_q;
    cursor_d  = cursor_q;
    scan_d    = scan_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    loc_d     = loc_q;
    del_d     = del_q;
    key_d     = key_q;
    res_d     = res_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_data;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = s_axis_tdata_i[KEY_W-1:0];
          del_d = (req == REQ_DELETE);
          res_d = '{found: 1'b0, key: '0, payload: '0, status: ST_OK};
          unique case (req)
            REQ_INSERT: begin
              if (count_q == CapCnt) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                wr_data = s_axis_tdata_i;
                count_d = count_q + CW'(1);
              end
            end
            REQ_DELETE, REQ_RETRIEVE: begin
              if (count_q == '0) begin
                res_d.status = ST_NOT_FOUND;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                scan_d    = CW'(1);
                cmp_vld_d = 1'b1;
                cmp_idx_d = '0;
              end
            end
            REQ_EMPTY: count_d = '0;
            REQ_RESET_ITER: cursor_d = '0;
            REQ_NEXT: begin
              if (cursor_q < count_q) begin
                rd_en   = 1'b1;
                rd_addr = cursor_q[AW-1:0];
              end else begin
                res_d.status = ST_AT_END;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmp_vld_d = 1'b0;
        if (hit) begin
          res_d = '{found: 1'b1, key: rd_key, payload: rd_data[REC_W-1:KEY_W],
                    status: ST_OK};
          loc_d = cmp_idx_q[AW-1:0];
          if (del_q) begin
            rd_en   = 1'b1;
            rd_addr = last_idx[AW-1:0];
          end
        end else begin
          if (scan_end) begin
            res_d.status = ST_NOT_FOUND;
          end
          if (scan_q < count_q) begin
            rd_en     = 1'b1;
            rd_addr   = scan_q[AW-1:0];
            scan_d    = scan_q + CW'(1);
            cmp_vld_d = 1'b1;
            cmp_idx_d = scan_q;
          end
        end
      end
      S_MOVE: begin
        // last record fills the hole
        wr_en   = 1'b1;
        wr_addr = loc_q;
        wr_data = rd_data;
        count_d = count_q - CW'(1);
      end
      S_NEXT: begin
        res_d = '{found: 1'b1, key: rd_key, payload: rd_data[REC_W-1:KEY_W],
                  status: ST_OK};
        cursor_d = cursor_q + CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {PAD_W'(0), (count_q == CapCnt), cnt_ext[CNT_OUT_W-1:0],
                       res_q.payload, res_q.key, res_q.found};
          m_user_d  = res_q.status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    loc_q     <= loc_d;
    del_q     <= del_d;
    key_q     <= key_d;
    res_q     <= res_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_IDLE || state_q == S_MOVE))
    else $error("memory write outside insert or move");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req == REQ_INSERT && count_q != CapCnt) |=>
      (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_q.found) |-> (res_q.status == ST_OK))
    else $error("found result with error status");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> (state_q == S_DONE))
    else $error("result dropped while output busy");

endmodule
